[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled while
// rst_ni is low. Defining NO_ASSERTIONS compiles them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// When the trigger holds, the check holds at the same edge.
`define ASSERT_IMPLY(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (chk)) \
    else $error(msg);

// When the trigger holds, the check holds at the next edge.
`define ASSERT_NEXT(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (chk)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, trig, chk, msg)
`define ASSERT_NEXT(lbl, trig, chk, msg)

`endif

`endif

[sv/plob_pkg.sv]
// ---------------------------------------------------------------------------
// Price level order book package
// Item types, field widths and the command set shared by the cell row, the
// side controller and the top level.
// ---------------------------------------------------------------------------
package plob_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned MID_W   = 33;

  // Request kinds carried in req_type.
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Side codes.
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // Input item.
  typedef struct packed {
    logic               req_type;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } plob_in_t;

  // Result item.
  typedef struct packed {
    logic [PRICE_W-1:0] best_bid;
    logic               bid_valid;
    logic [PRICE_W-1:0] best_ask;
    logic               ask_valid;
    logic [DEPTH_W-1:0] depth;
    logic [MID_W-1:0]   mid_twice;
    logic               overflow;
  } plob_out_t;

  // One price level as held by a cell.
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   size;
  } plob_level_t;

  // Operation applied by every cell of a side in the apply cycle.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } plob_op_e;

  // Command from the top level to one side.
  typedef struct packed {
    logic        eval;
    logic        apply;
    logic        clear;
    logic        descending;
    plob_level_t level;
  } plob_side_cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_RESULT
  } plob_state_e;

endpackage

[sv/plob_cell.sv]
// ---------------------------------------------------------------------------
// Price level cell
// Holds one price level of a side. In the compare cycle it records whether
// the request price belongs in front of it and whether it matches. In the
// apply cycle it keeps, rewrites, or takes the request, left or right cell.
// ---------------------------------------------------------------------------
module plob_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 eval_i,
  input  plob_pkg::plob_op_e   op_i,
  input  logic                 descending_i,
  input  plob_pkg::plob_level_t req_i,
  input  logic                 valid_i,
  input  plob_pkg::plob_level_t left_i,
  input  logic                 left_before_i,
  input  plob_pkg::plob_level_t right_i,
  output plob_pkg::plob_level_t level_o,
  output logic                 before_o,
  output logic                 match_o
);

  plob_pkg::plob_level_t level_q, level_d;
  logic                  before_q, before_d;
  logic                  match_q, match_d;

  // Compare the held level against the request price.
  always_comb begin
    before_d = before_q;
    match_d  = match_q;
    if (eval_i) begin
      if (descending_i) begin
        before_d = !valid_i || (level_q.price < req_i.price);
      end else begin
        before_d = !valid_i || (level_q.price > req_i.price);
      end
      match_d = valid_i && (level_q.price == req_i.price);
    end
  end

  // Apply the side operation using the recorded flags.
  always_comb begin
    level_d = level_q;
    unique case (op_i)
      plob_pkg::OP_WRITE: begin
        if (match_q) begin
          level_d.size = req_i.size;
        end
      end
      plob_pkg::OP_INSERT: begin
        if (before_q) begin
          if (left_before_i) begin
            level_d = left_i;
          end else begin
            level_d = req_i;
          end
        end
      end
      plob_pkg::OP_REMOVE: begin
        if (before_q || match_q) begin
          level_d = right_i;
        end
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  // Flags are control state; the level itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      before_q <= before_d;
      match_q  <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign level_o  = level_q;
  assign before_o = before_q;
  assign match_o  = match_q;

endmodule

[sv/plob_side.sv]
// ---------------------------------------------------------------------------
// Order book side
// A row of LEVELS cells kept sorted best-first, plus the level count. It
// turns a command into the operation that every cell applies and reports
// the best level, the count and whether an insert dropped a level.
// ---------------------------------------------------------------------------
module plob_side #(
  parameter int unsigned LEVELS = 32,
  parameter int unsigned CNT_W  = $clog2(LEVELS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  plob_pkg::plob_side_cmd_t cmd_i,
  output logic [plob_pkg::PRICE_W-1:0] best_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     drop_o
);

  `include "assert_macros.svh"

  logic [CNT_W-1:0]      count_q, count_d;
  plob_pkg::plob_level_t level [LEVELS];
  logic [LEVELS-1:0]     in_front;
  logic [LEVELS-1:0]     match;
  logic [LEVELS-1:0]     valid;
  logic                  any_match;
  logic                  full;
  logic                  qty_zero;
  plob_pkg::plob_op_e    op;

  assign any_match = |match;
  assign full      = (count_q == CNT_W'(LEVELS));
  assign qty_zero  = (cmd_i.level.size == '0);

  // Decide the row operation for the apply cycle.
  always_comb begin
    op = plob_pkg::OP_NONE;
    if (cmd_i.apply) begin
      if (qty_zero) begin
        op = any_match ? plob_pkg::OP_REMOVE : plob_pkg::OP_NONE;
      end else begin
        op = any_match ? plob_pkg::OP_WRITE : plob_pkg::OP_INSERT;
      end
    end
  end

  assign drop_o = (op == plob_pkg::OP_INSERT) && full;

  // Level count follows the row operation.
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (op == plob_pkg::OP_REMOVE) begin
      count_d = count_q - CNT_W'(1);
    end else if ((op == plob_pkg::OP_INSERT) && !full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The row of cells; each one sees its two neighbors.
  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    plob_pkg::plob_level_t left_lvl;
    plob_pkg::plob_level_t right_lvl;
    logic                  left_before;

    assign valid[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_lvl    = cmd_i.level;
      assign left_before = 1'b0;
    end else begin : g_inner
      assign left_lvl    = level[i-1];
      assign left_before = in_front[i-1];
    end

    if (i == LEVELS - 1) begin : g_last
      assign right_lvl = level[i];
    end else begin : g_body
      assign right_lvl = level[i+1];
    end

    plob_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .eval_i        (cmd_i.eval),
      .op_i          (op),
      .descending_i  (cmd_i.descending),
      .req_i         (cmd_i.level),
      .valid_i       (valid[i]),
      .left_i        (left_lvl),
      .left_before_i (left_before),
      .right_i       (right_lvl),
      .level_o       (level[i]),
      .before_o      (in_front[i]),
      .match_o       (match[i])
    );
  end

  assign best_o  = level[0].price;
  assign count_o = count_q;

  `ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_W'(LEVELS),
    "Level count exceeds the number of cells.")
  `ASSERT_IMPLY(a_drop_only_full, drop_o, full && !any_match,
    "A level was dropped while the side had room or the price matched.")
  `ASSERT_NEXT(a_insert_grows, (op == plob_pkg::OP_INSERT) && !full && !cmd_i.clear,
    count_q == $past(count_q) + CNT_W'(1), "Insert into a side with room did not grow it.")

endmodule

[sv/price_level_order_book.sv]
// ---------------------------------------------------------------------------
// Price level order book
// Top level: request register, sequencer, bid and ask sides, result register.
// ---------------------------------------------------------------------------
// An accepted item is registered; then every cell of the addressed side
// compares its level with the request price, the cells apply the update
// together (overwrite, insert with a shift toward the worse end, or removal
// with a shift toward the best end), and the result is formed. The block
// accepts no new item until it is through with the last one. The result is
// held in an output register, so the next item is accepted while a result
// waits; the block only stalls in the result cycle until the register is
// free. Both sides hold LEVELS levels in a row of cells, with no clearing
// pass after reset.
module price_level_order_book #(
  parameter int unsigned LEVELS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plob_pkg::plob_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plob_pkg::plob_out_t out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(LEVELS + 1);

  plob_pkg::plob_state_e state_q, state_d;
  plob_pkg::plob_in_t    req_q;
  plob_pkg::plob_out_t   out_q, out_d;
  logic                  out_valid_q;
  logic                  ovf_q, ovf_d;
  logic                  in_accept;
  logic                  out_take;
  logic                  result_load;
  logic                  eval_en;
  logic                  apply_en;

  plob_pkg::plob_side_cmd_t bid_cmd, ask_cmd;
  logic [plob_pkg::PRICE_W-1:0] bid_best, ask_best;
  logic [CNT_W-1:0]             bid_count, ask_count;
  logic                         bid_drop, ask_drop;
  logic [CNT_W-1:0]             depth_max;
  logic [CNT_W+plob_pkg::DEPTH_W-1:0] depth_wide;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plob_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = plob_pkg::ST_EVAL;
        end
      end
      plob_pkg::ST_EVAL:  state_d = plob_pkg::ST_APPLY;
      plob_pkg::ST_APPLY: state_d = plob_pkg::ST_RESULT;
      plob_pkg::ST_RESULT: begin
        if (!out_valid_q || out_take) begin
          state_d = plob_pkg::ST_IDLE;
        end
      end
      default: state_d = plob_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o  = 1'b1;
    eval_en     = 1'b0;
    apply_en    = 1'b0;
    result_load = 1'b0;
    unique case (state_q)
      plob_pkg::ST_IDLE:   in_stall_o  = 1'b0;
      plob_pkg::ST_EVAL:   eval_en     = 1'b1;
      plob_pkg::ST_APPLY:  apply_en    = 1'b1;
      plob_pkg::ST_RESULT: result_load = !out_valid_q || out_take;
      default:             in_stall_o  = 1'b1;
    endcase
  end

  // Side commands; a clear request reaches both sides in the apply cycle.
  always_comb begin
    bid_cmd.eval       = eval_en && (req_q.req_type == plob_pkg::REQ_UPDATE) &&
                         (req_q.side == plob_pkg::SIDE_BID);
    bid_cmd.apply      = apply_en && (req_q.req_type == plob_pkg::REQ_UPDATE) &&
                         (req_q.side == plob_pkg::SIDE_BID);
    bid_cmd.clear      = apply_en && (req_q.req_type == plob_pkg::REQ_CLEAR);
    bid_cmd.descending = 1'b1;
    bid_cmd.level      = '{price: req_q.price, size: req_q.quantity};

    ask_cmd.eval       = eval_en && (req_q.req_type == plob_pkg::REQ_UPDATE) &&
                         (req_q.side == plob_pkg::SIDE_ASK);
    ask_cmd.apply      = apply_en && (req_q.req_type == plob_pkg::REQ_UPDATE) &&
                         (req_q.side == plob_pkg::SIDE_ASK);
    ask_cmd.clear      = bid_cmd.clear;
    ask_cmd.descending = 1'b0;
    ask_cmd.level      = bid_cmd.level;
  end

  plob_side #(.LEVELS(LEVELS), .CNT_W(CNT_W)) u_bid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (bid_cmd),
    .best_o  (bid_best),
    .count_o (bid_count),
    .drop_o  (bid_drop)
  );

  plob_side #(.LEVELS(LEVELS), .CNT_W(CNT_W)) u_ask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (ask_cmd),
    .best_o  (ask_best),
    .count_o (ask_count),
    .drop_o  (ask_drop)
  );

  // Overflow is caught in the apply cycle and kept for the result.
  always_comb begin
    ovf_d = ovf_q;
    if (apply_en) begin
      ovf_d = bid_drop || ask_drop;
    end
  end

  // Result fields from the head cells and the counts.
  assign depth_max  = (bid_count > ask_count) ? bid_count : ask_count;
  assign depth_wide = {{plob_pkg::DEPTH_W{1'b0}}, depth_max};

  always_comb begin
    out_d.bid_valid = (bid_count != '0);
    out_d.ask_valid = (ask_count != '0);
    out_d.best_bid  = out_d.bid_valid ? bid_best : '0;
    out_d.best_ask  = out_d.ask_valid ? ask_best : '0;
    out_d.depth     = depth_wide[plob_pkg::DEPTH_W-1:0];
    out_d.mid_twice = (out_d.bid_valid && out_d.ask_valid) ?
                      ({1'b0, bid_best} + {1'b0, ask_best}) : '0;
    out_d.overflow  = ovf_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plob_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (result_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_one_item_in_flight, in_accept, in_stall_o,
    "A second item was accepted while one was still in work.")
  `ASSERT_IMPLY(a_clear_empties,
    (state_q == plob_pkg::ST_RESULT) && (req_q.req_type == plob_pkg::REQ_CLEAR),
    (bid_count == '0) && (ask_count == '0), "A clear request left levels behind.")
  `ASSERT_IMPLY(a_result_from_seq, $rose(out_valid_o),
    $past(state_q == plob_pkg::ST_RESULT), "A result appeared outside the result cycle.")

endmodule

[tb/price_level_order_book_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Price level order book testbench
// Sends level updates and clears over the valid/stall input channel and
// checks every result item, field by field, against the directed table or
// a book kept in the bench. A short directed table comes first. Then each
// side is filled past capacity, and then random snapshot loads are followed
// by incremental updates. Idling patterns vary between phases, and one long
// output hold-off backs the block up until it stalls its input.
// ---------------------------------------------------------------------------
module price_level_order_book_tb;

  localparam int unsigned BOOK_LEVELS  = 32;
  localparam int unsigned ITEM_TARGET  = 400;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DIR_ROWS     = 19;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    plob_pkg::plob_in_t  req;
    bit                  typed;
    plob_pkg::plob_out_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  plob_pkg::plob_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  plob_pkg::plob_out_t out_data_o;

  // Book kept by the bench: index 0 of each side is its best level.
  logic [plob_pkg::PRICE_W-1:0] book_px [2][BOOK_LEVELS];
  logic [plob_pkg::QTY_W-1:0]   book_sz [2][BOOK_LEVELS];
  int                           book_n  [2];

  plob_pkg::plob_out_t top_of_book_q [$];
  dir_row_t            dir_rows [DIR_ROWS];
  int unsigned         mismatch_count;
  int unsigned         items_sent;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         stuck_cycles;
  // Bumped by the main sequence each time it wants a long output hold-off.
  int unsigned         hold_seq;

  price_level_order_book #(
    .LEVELS(BOOK_LEVELS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic plob_pkg::plob_in_t level_request(
    logic rt, logic sd, logic [plob_pkg::PRICE_W-1:0] p, logic [plob_pkg::QTY_W-1:0] q);
    plob_pkg::plob_in_t r;
    r.req_type = rt;
    r.side     = sd;
    r.price    = p;
    r.quantity = q;
    return r;
  endfunction

  function automatic plob_pkg::plob_out_t book_view(
    logic [plob_pkg::PRICE_W-1:0] bb, logic bv,
    logic [plob_pkg::PRICE_W-1:0] ba, logic av,
    logic [plob_pkg::DEPTH_W-1:0] dp, logic [plob_pkg::MID_W-1:0] mid,
    logic ovf);
    plob_pkg::plob_out_t r;
    r.best_bid  = bb;
    r.bid_valid = bv;
    r.best_ask  = ba;
    r.ask_valid = av;
    r.depth     = dp;
    r.mid_twice = mid;
    r.overflow  = ovf;
    return r;
  endfunction

  function automatic logic [plob_pkg::QTY_W-1:0] random_size();
    logic [plob_pkg::QTY_W-1:0] q;
    q = $urandom;
    return (q == '0) ? 1 : q;
  endfunction

  // Apply one level change to a side of the bench book; returns the drop flag.
  function automatic logic apply_level_change(logic sd, logic [plob_pkg::PRICE_W-1:0] p,
                                              logic [plob_pkg::QTY_W-1:0] q);
    int n;
    int hit;
    int pos;
    int k;
    n   = book_n[sd];
    hit = n;
    pos = n;
    for (k = 0; k < n; k++) begin
      if (hit == n && book_px[sd][k] == p) hit = k;
    end

    // Zero quantity removes the level, shifting worse levels toward the top.
    if (q == '0) begin
      if (hit < n) begin
        for (k = hit; k < n - 1; k++) begin
          book_px[sd][k] = book_px[sd][k + 1];
          book_sz[sd][k] = book_sz[sd][k + 1];
        end
        book_n[sd] = n - 1;
      end
      return 1'b0;
    end

    // A known price only gets its size overwritten.
    if (hit < n) begin
      book_sz[sd][hit] = q;
      return 1'b0;
    end

    // Find the first level that the new price beats.
    for (k = 0; k < n; k++) begin
      if (pos == n && ((sd == plob_pkg::SIDE_BID) ? (book_px[sd][k] < p)
                                                  : (book_px[sd][k] > p)))
        pos = k;
    end

    if (n < BOOK_LEVELS) begin
      for (k = n; k > pos; k--) begin
        book_px[sd][k] = book_px[sd][k - 1];
        book_sz[sd][k] = book_sz[sd][k - 1];
      end
      book_px[sd][pos] = p;
      book_sz[sd][pos] = q;
      book_n[sd] = n + 1;
      return 1'b0;
    end

    // Full side: the worst level falls off, or the new one is not kept.
    if (pos < n) begin
      for (k = n - 1; k > pos; k--) begin
        book_px[sd][k] = book_px[sd][k - 1];
        book_sz[sd][k] = book_sz[sd][k - 1];
      end
      book_px[sd][pos] = p;
      book_sz[sd][pos] = q;
    end
    return 1'b1;
  endfunction

  // Update the bench book with one request and form the expected result.
  function automatic plob_pkg::plob_out_t predict_top_of_book(plob_pkg::plob_in_t it);
    plob_pkg::plob_out_t r;
    logic                ovf;
    int unsigned         deepest;
    r   = '0;
    ovf = 1'b0;
    if (it.req_type == plob_pkg::REQ_CLEAR) begin
      book_n[plob_pkg::SIDE_BID] = 0;
      book_n[plob_pkg::SIDE_ASK] = 0;
    end else begin
      ovf = apply_level_change(it.side, it.price, it.quantity);
    end
    r.bid_valid = (book_n[plob_pkg::SIDE_BID] != 0);
    r.ask_valid = (book_n[plob_pkg::SIDE_ASK] != 0);
    if (r.bid_valid) r.best_bid = book_px[plob_pkg::SIDE_BID][0];
    if (r.ask_valid) r.best_ask = book_px[plob_pkg::SIDE_ASK][0];
    if (r.bid_valid && r.ask_valid) r.mid_twice = {1'b0, r.best_bid} + {1'b0, r.best_ask};
    deepest = (book_n[plob_pkg::SIDE_BID] > book_n[plob_pkg::SIDE_ASK]) ?
              book_n[plob_pkg::SIDE_BID] : book_n[plob_pkg::SIDE_ASK];
    r.depth    = deepest[plob_pkg::DEPTH_W-1:0];
    r.overflow = ovf;
    return r;
  endfunction

  // Offer one item after an optional idle gap and wait until it is taken.
  task automatic offer_request(plob_pkg::plob_in_t it, bit typed, plob_pkg::plob_out_t want);
    plob_pkg::plob_out_t model;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model = predict_top_of_book(it);
    top_of_book_q.push_back(typed ? want : model);
    items_sent++;
  endtask

  // One random request: inserts near a base price, overwrites and removals of
  // levels present in the book, removals of absent prices and rare clears.
  task automatic offer_random_update(logic [plob_pkg::PRICE_W-1:0] base, logic bias, bit load);
    plob_pkg::plob_in_t           it;
    logic                         sd;
    int unsigned                  roll;
    logic [plob_pkg::PRICE_W-1:0] p;
    sd   = ($urandom_range(99) < 70) ? bias : ~bias;
    roll = load ? 99 : $urandom_range(99);
    if ($urandom_range(9) == 0) p = $urandom;
    else p = base + $urandom_range(400) - 200;
    if (roll < 3) begin
      it = level_request(plob_pkg::REQ_CLEAR, $urandom_range(1) == 1, $urandom, $urandom);
    end else if (roll < 55 && book_n[sd] != 0) begin
      p  = book_px[sd][$urandom_range(book_n[sd] - 1)];
      it = level_request(plob_pkg::REQ_UPDATE, sd, p, (roll < 30) ? random_size() : '0);
    end else if (roll < 62) begin
      it = level_request(plob_pkg::REQ_UPDATE, sd, $urandom, '0);
    end else begin
      it = level_request(plob_pkg::REQ_UPDATE, sd, p, random_size());
    end
    offer_request(it, 1'b0, '0);
  endtask

  // Fill one side to capacity, then push in better, worse and middle prices.
  task automatic fill_side_past_full(logic sd);
    logic [plob_pkg::PRICE_W-1:0] base;
    logic [plob_pkg::PRICE_W-1:0] p;
    base = $urandom_range(32'hF000_0000, 32'h0010_0000);
    offer_request(level_request(plob_pkg::REQ_CLEAR, sd, base, '0), 1'b0, '0);
    while (book_n[sd] < BOOK_LEVELS)
      offer_request(level_request(plob_pkg::REQ_UPDATE, sd, base + $urandom_range(60000),
                                  random_size()), 1'b0, '0);
    // A price better than the best level pushes the worst one out.
    p = (sd == plob_pkg::SIDE_BID) ? book_px[sd][0] + $urandom_range(50, 1)
                                   : book_px[sd][0] - $urandom_range(50, 1);
    offer_request(level_request(plob_pkg::REQ_UPDATE, sd, p, random_size()), 1'b0, '0);
    // A price worse than the worst level is itself dropped.
    p = (sd == plob_pkg::SIDE_BID) ? book_px[sd][BOOK_LEVELS-1] - $urandom_range(50, 1)
                                   : book_px[sd][BOOK_LEVELS-1] + $urandom_range(50, 1);
    offer_request(level_request(plob_pkg::REQ_UPDATE, sd, p, random_size()), 1'b0, '0);
    offer_request(level_request(plob_pkg::REQ_UPDATE, sd, base + $urandom_range(60000),
                                random_size()), 1'b0, '0);
    // Overwrite while full, then free a slot and take it again.
    p = book_px[sd][$urandom_range(BOOK_LEVELS - 1)];
    offer_request(level_request(plob_pkg::REQ_UPDATE, sd, p, random_size()), 1'b0, '0);
    p = book_px[sd][$urandom_range(BOOK_LEVELS - 1)];
    offer_request(level_request(plob_pkg::REQ_UPDATE, sd, p, '0), 1'b0, '0);
    offer_request(level_request(plob_pkg::REQ_UPDATE, sd, base + $urandom_range(60000),
                                random_size()), 1'b0, '0);
  endtask

  // A snapshot load (clear plus levels, mostly on one side) and live updates.
  task automatic offer_episode();
    logic [plob_pkg::PRICE_W-1:0] base;
    logic                         bias;
    int unsigned                  n_load;
    int unsigned                  n_upd;
    base   = $urandom;
    bias   = ($urandom_range(1) == 1);
    n_load = $urandom_range(70, 3);
    n_upd  = $urandom_range(40, 10);
    offer_request(level_request(plob_pkg::REQ_CLEAR, $urandom_range(1) == 1, $urandom,
                                $urandom), 1'b0, '0);
    repeat (n_load) offer_random_update(base, bias, 1'b1);
    repeat (n_upd) offer_random_update(base, bias, 1'b0);
  endtask

  task automatic set_idle_phase(int unsigned ph);
    case (ph % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 51;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 51;
      end
      default: begin
        send_idle_pct  = 15;
        recv_stall_pct = 15;
      end
    endcase
  endtask

  task automatic check_top_of_book(plob_pkg::plob_out_t got);
    plob_pkg::plob_out_t want;
    if (top_of_book_q.size() == 0) begin
      $error("result item arrived with none expected");
      mismatch_count++;
    end else begin
      want = top_of_book_q.pop_front();
      if (got.best_bid !== want.best_bid) begin
        $error("best_bid: expected %0h, got %0h", want.best_bid, got.best_bid);
        mismatch_count++;
      end
      if (got.bid_valid !== want.bid_valid) begin
        $error("bid_valid: expected %0b, got %0b", want.bid_valid, got.bid_valid);
        mismatch_count++;
      end
      if (got.best_ask !== want.best_ask) begin
        $error("best_ask: expected %0h, got %0h", want.best_ask, got.best_ask);
        mismatch_count++;
      end
      if (got.ask_valid !== want.ask_valid) begin
        $error("ask_valid: expected %0b, got %0b", want.ask_valid, got.ask_valid);
        mismatch_count++;
      end
      if (got.depth !== want.depth) begin
        $error("depth: expected %0d, got %0d", want.depth, got.depth);
        mismatch_count++;
      end
      if (got.mid_twice !== want.mid_twice) begin
        $error("mid_twice: expected %0h, got %0h", want.mid_twice, got.mid_twice);
        mismatch_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        mismatch_count++;
      end
    end
  endtask

  // Result items are checked at the edge where they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_top_of_book(out_data_o);
  end

  // Give up when neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("price_level_order_book: mismatch");
      $finish;
    end
  end

  // Output side: random stalls, or a counted hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_seq;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int row;
    int unsigned ep;
    rst_ni                     = 1'b0;
    in_valid_i                 = 1'b0;
    in_data_i                  = '0;
    book_n[plob_pkg::SIDE_BID] = 0;
    book_n[plob_pkg::SIDE_ASK] = 0;
    items_sent                 = 0;
    hold_seq                   = 0;
    set_idle_phase(0);

    // Directed table: empty book, extremes, every operation, crossed book.
    dir_rows[0]  = '{level_request(plob_pkg::REQ_CLEAR, plob_pkg::SIDE_BID, '0, '0),
                     1'b1, '0};
    dir_rows[1]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, 32'd1234, '0),
                     1'b1, '0};
    dir_rows[2]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, 32'd77, '0),
                     1'b1, '0};
    dir_rows[3]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF), 1'b1,
                     book_view(32'hFFFF_FFFF, 1'b1, '0, 1'b0, 6'd1, '0, 1'b0)};
    dir_rows[4]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, 32'hFFFF_FFFF,
                                   32'd1), 1'b1,
                     book_view(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 6'd1,
                               33'h1_FFFF_FFFE, 1'b0)};
    dir_rows[5]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, '0,
                                   32'h8000_0000), 1'b0, '0};
    dir_rows[6]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, '0, 32'd1),
                     1'b0, '0};
    dir_rows[7]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, 32'hFFFF_FFFF,
                                   32'd5), 1'b0, '0};
    dir_rows[8]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, '0, '0),
                     1'b0, '0};
    dir_rows[9]  = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, '0, '0),
                     1'b0, '0};
    dir_rows[10] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, 32'h5555_5555,
                                   32'hAAAA_AAAA), 1'b0, '0};
    dir_rows[11] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, 32'hAAAA_AAAA,
                                   32'h5555_5555), 1'b0, '0};
    dir_rows[12] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, 32'h1234_5678,
                                   '0), 1'b0, '0};
    dir_rows[13] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, 32'hFFFF_FFFF,
                                   '0), 1'b0, '0};
    dir_rows[14] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, 32'd100, 32'd9),
                     1'b0, '0};
    dir_rows[15] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_ASK, 32'h7FFF_FFFF,
                                   32'd3), 1'b0, '0};
    dir_rows[16] = '{level_request(plob_pkg::REQ_CLEAR, plob_pkg::SIDE_ASK, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF), 1'b1, '0};
    dir_rows[17] = '{level_request(plob_pkg::REQ_UPDATE, plob_pkg::SIDE_BID, '0,
                                   32'hFFFF_FFFF), 1'b1,
                     book_view('0, 1'b1, '0, 1'b0, 6'd1, '0, 1'b0)};
    dir_rows[18] = '{level_request(plob_pkg::REQ_CLEAR, plob_pkg::SIDE_BID, '0, '0),
                     1'b1, '0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < DIR_ROWS; row++)
      offer_request(dir_rows[row].req, dir_rows[row].typed, dir_rows[row].want);

    // Overflow on both sides, under different idling.
    set_idle_phase(2);
    fill_side_past_full(plob_pkg::SIDE_BID);
    set_idle_phase(1);
    fill_side_past_full(plob_pkg::SIDE_ASK);

    // Long output hold-off while items keep coming, so the block backs up.
    set_idle_phase(0);
    hold_seq++;
    ep = 0;
    while (items_sent < ITEM_TARGET) begin
      offer_episode();
      ep++;
      set_idle_phase(ep);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (top_of_book_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("price_level_order_book: match");
    else
      $display("price_level_order_book: mismatch");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/plob_pkg.sv
sv/plob_cell.sv
sv/plob_side.sv
sv/price_level_order_book.sv
tb/price_level_order_book_tb.sv
